// ===== hw/rtl/btrc_pkg.sv =====
// ----------------------------------------------------------------------------
// btrc_pkg
// Types and constants shared by the button, toggle and relay controller.
// ----------------------------------------------------------------------------
package btrc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_PIN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_WRITE = 2'd3
  } req_e;

  localparam logic [2:0] ADDR_RELAY  = 3'd0;
  localparam logic [2:0] ADDR_LED    = 3'd1;
  localparam logic [2:0] ADDR_BUTTON = 3'd2;
  localparam logic [2:0] ADDR_TOGGLE = 3'd3;
  localparam logic [2:0] ADDR_FOLLOW = 3'd4;

  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_TICKS_SEC  = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd2;

  localparam logic [7:0] DEBOUNCE_RESET   = 8'd10;
  localparam logic [6:0] TICKS_SEC_RESET  = 7'd100;
  localparam logic [7:0] LONG_PRESS_RESET = 8'd10;

  localparam logic [7:0] STABLE_MAX = 8'hFF;
  localparam logic [1:0] BLINK_MAX  = 2'd3;
  localparam logic [1:0] BLINK_RESTART = 2'd2;

  typedef struct packed {
    logic        raw_pressed;
    logic [7:0]  stable_count;
    logic        button_pressed;
    logic        toggle_bit;
    logic        relay_bit;
    logic        led_bit;
    logic        follow_mode;
    logic [6:0]  tick_prescale;
    logic [31:0] seconds_count;
    logic [31:0] event_second;
    logic        long_handled;
    logic [1:0]  blink_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    raw_pressed:    1'b0,
    stable_count:   8'd0,
    button_pressed: 1'b0,
    toggle_bit:     1'b1,
    relay_bit:      1'b1,
    led_bit:        1'b1,
    follow_mode:    1'b1,
    tick_prescale:  7'd0,
    seconds_count:  32'd0,
    event_second:   32'd0,
    long_handled:   1'b0,
    blink_count:    2'd0
  };

  typedef struct packed {
    logic       read_data;
    logic       relay_drive;
    logic       led_lit;
    logic [4:0] changed_mask;
    logic       save_settings;
    logic [1:0] settings_byte;
    logic       factory_reset;
    logic       restart;
  } result_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [6:0] ticks_per_second;
    logic [7:0] long_press_seconds;
  } cfg_t;

endpackage

// ===== hw/rtl/button_toggle_relay_controller.sv =====
// ----------------------------------------------------------------------------
// button_toggle_relay_controller
// Debounced toggle button with long-press factory reset, driving a relay
// and an LED, with a small register access path.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o  | req_type, pin_level, reg_addr,
//           |                          | write_value
//  out      | out_valid_o / out_stall_i| read_data, relay_drive, led_lit,
//           |                          | changed_mask, save_settings,
//           |                          | settings_byte, factory_reset, restart
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An accepted item sits in the input register while the step logic feeds the
// result register, which offers its result. One item is accepted per cycle
// unless the input stalls. State is updated as an item enters the result
// register. A stalled result holds and backs up the input register; the input
// stalls only while its register holds an item that cannot advance. Reset
// clears the valid flags and loads state and configuration, not the payloads.
// ----------------------------------------------------------------------------
module button_toggle_relay_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic       pin_level_i,
  input  logic [2:0] reg_addr_i,
  input  logic       write_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       read_data_o,
  output logic       relay_drive_o,
  output logic       led_lit_o,
  output logic [4:0] changed_mask_o,
  output logic       save_settings_o,
  output logic [1:0] settings_byte_o,
  output logic       factory_reset_o,
  output logic       restart_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  btrc_pkg::cfg_t    cfg_q;
  btrc_pkg::state_t  state_q;
  btrc_pkg::state_t  state_d;
  btrc_pkg::result_t res_q;
  btrc_pkg::result_t res_d;

  logic           in_valid_q;
  btrc_pkg::req_e req_q;
  logic           pin_q;
  logic [2:0]     addr_q;
  logic           wval_q;
  logic           out_valid_q;
  logic           out_free;
  logic           advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= btrc_pkg::DEBOUNCE_RESET;
      cfg_q.ticks_per_second   <= btrc_pkg::TICKS_SEC_RESET;
      cfg_q.long_press_seconds <= btrc_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        btrc_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ticks     <= cfg_data_i;
        btrc_pkg::CFG_TICKS_SEC:  cfg_q.ticks_per_second   <= cfg_data_i[6:0];
        btrc_pkg::CFG_LONG_PRESS: cfg_q.long_press_seconds <= cfg_data_i;
        default: ; // unmapped index: drop
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_q  <= btrc_pkg::req_e'(req_type_i);
      pin_q  <= pin_level_i;
      addr_q <= reg_addr_i;
      wval_q <= write_value_i;
    end
  end

  btrc_step u_step (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .req_type_i    (req_q),
    .pin_level_i   (pin_q),
    .reg_addr_i    (addr_q),
    .write_value_i (wval_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btrc_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_data;
  assign relay_drive_o   = res_q.relay_drive;
  assign led_lit_o       = res_q.led_lit;
  assign changed_mask_o  = res_q.changed_mask;
  assign save_settings_o = res_q.save_settings;
  assign settings_byte_o = res_q.settings_byte;
  assign factory_reset_o = res_q.factory_reset;
  assign restart_o       = res_q.restart;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item missing from result register");

  a_freset_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.factory_reset || res_q.restart)) |-> state_q.long_handled)
    else $error("reset pulse without long press recorded");

  a_blink_after_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.blink_count != 2'd0) |-> state_q.long_handled)
    else $error("blink count running without long press");

endmodule

// ===== hw/rtl/btrc_step.sv =====
// ----------------------------------------------------------------------------
// btrc_step
// Next state and result for one request: debounce, toggle, relay follow,
// seconds prescaler, long-press detection and register access.
// ----------------------------------------------------------------------------
module btrc_step (
  input  btrc_pkg::state_t  state_i,
  input  btrc_pkg::cfg_t    cfg_i,
  input  btrc_pkg::req_e    req_type_i,
  input  logic              pin_level_i,
  input  logic [2:0]        reg_addr_i,
  input  logic              write_value_i,
  output btrc_pkg::state_t  state_o,
  output btrc_pkg::result_t result_o
);

  btrc_pkg::state_t s;
  logic        adopt;
  logic        press;
  logic [7:0]  presc_inc;
  logic [31:0] sec_inc;
  logic [31:0] held_secs;
  logic        rd;
  logic [4:0]  changed;
  logic        save;
  logic        freset;
  logic        rst;

  assign adopt     = (state_i.stable_count >= cfg_i.debounce_ticks) &&
                     (state_i.raw_pressed != state_i.button_pressed);
  assign press     = adopt && state_i.raw_pressed;
  assign presc_inc = {1'b0, state_i.tick_prescale} + 8'd1;
  assign sec_inc   = state_i.seconds_count + 32'd1;

  always_comb begin
    s         = state_i;
    rd        = 1'b0;
    changed   = '0;
    save      = 1'b0;
    freset    = 1'b0;
    rst       = 1'b0;
    held_secs = sec_inc - s.event_second;
    case (req_type_i)
      btrc_pkg::REQ_TICK: begin
        if (adopt) begin
          s.button_pressed = state_i.raw_pressed;
          s.event_second   = state_i.seconds_count;
          changed[btrc_pkg::ADDR_BUTTON] = 1'b1;
          if (press) begin
            s.toggle_bit = ~state_i.toggle_bit;
            changed[btrc_pkg::ADDR_TOGGLE] = 1'b1;
          end
          if (state_i.follow_mode) begin
            s.relay_bit = s.toggle_bit;
            changed[btrc_pkg::ADDR_RELAY] = 1'b1;
            save = 1'b1;
          end
        end
        if (state_i.stable_count != btrc_pkg::STABLE_MAX) begin
          s.stable_count = state_i.stable_count + 8'd1;
        end
        held_secs = sec_inc - s.event_second;
        if (presc_inc < {1'b0, cfg_i.ticks_per_second}) begin
          s.tick_prescale = presc_inc[6:0];
        end else begin
          // one second passed
          s.tick_prescale = '0;
          s.seconds_count = sec_inc;
          if (!state_i.long_handled && s.button_pressed &&
              (held_secs > {24'd0, cfg_i.long_press_seconds})) begin
            s.long_handled = 1'b1;
            freset = 1'b1;
          end
          if (s.long_handled) begin
            if (state_i.blink_count != btrc_pkg::BLINK_MAX) begin
              s.blink_count = state_i.blink_count + 2'd1;
            end
            rst = (s.blink_count >= btrc_pkg::BLINK_RESTART);
          end
        end
      end
      btrc_pkg::REQ_PIN: begin
        s.raw_pressed  = ~pin_level_i;
        s.stable_count = '0;
      end
      btrc_pkg::REQ_READ: begin
        case (reg_addr_i)
          btrc_pkg::ADDR_RELAY:  rd = state_i.relay_bit;
          btrc_pkg::ADDR_LED:    rd = state_i.led_bit;
          btrc_pkg::ADDR_BUTTON: rd = state_i.button_pressed;
          btrc_pkg::ADDR_TOGGLE: rd = state_i.toggle_bit;
          btrc_pkg::ADDR_FOLLOW: rd = state_i.follow_mode;
          default:               rd = 1'b0;
        endcase
      end
      btrc_pkg::REQ_WRITE: begin
        case (reg_addr_i)
          btrc_pkg::ADDR_RELAY: begin
            s.relay_bit = write_value_i;
            changed[btrc_pkg::ADDR_RELAY] = 1'b1;
            save = 1'b1;
          end
          btrc_pkg::ADDR_LED: begin
            s.led_bit = write_value_i;
            changed[btrc_pkg::ADDR_LED] = 1'b1;
          end
          btrc_pkg::ADDR_FOLLOW: begin
            s.follow_mode = write_value_i;
            changed[btrc_pkg::ADDR_FOLLOW] = 1'b1;
            save = 1'b1;
          end
          default: ; // read-only or unmapped: drop
        endcase
      end
      default: ;
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.read_data     = rd;
    result_o.relay_drive   = s.relay_bit;
    // blink overrides the LED once a long press was seen
    result_o.led_lit       = s.long_handled ? s.seconds_count[0] : s.led_bit;
    result_o.changed_mask  = changed;
    result_o.save_settings = save;
    result_o.settings_byte = {s.follow_mode, s.relay_bit};
    result_o.factory_reset = freset;
    result_o.restart       = rst;
  end

endmodule
